### src/swarq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swarq_pkg;

    localparam int SEQ_W      = 16;
    localparam int ADDR_W     = 8;
    localparam int ID_W       = 8;
    localparam int LEN_W      = 16;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELIABLE = 2'd1;

    // Reset values of the configuration registers
    localparam logic [SEQ_W-1:0] MAX_SEQ_RST  = 16'hFFFF;
    localparam logic             RELIABLE_RST = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOT_DATA = 2'd1,
        STAT_RANGE    = 2'd2
    } status_t;

    typedef struct packed {
        logic              frame_kind;
        logic [SEQ_W-1:0]  seq_num;
        logic [ADDR_W-1:0] source_addr;
        logic [ADDR_W-1:0] dest_addr;
        logic [ID_W-1:0]   source_id;
        logic [ID_W-1:0]   dest_id;
        logic [LEN_W-1:0]  payload_bytes;
    } frame_t;

    typedef struct packed {
        status_t           status;
        logic              deliver;
        logic              send_ack;
        logic [SEQ_W-1:0]  ack_seq;
        logic [ADDR_W-1:0] ack_dest_addr;
        logic [ADDR_W-1:0] ack_source_addr;
        logic [ID_W-1:0]   ack_dest_id;
        logic [ID_W-1:0]   ack_source_id;
        logic [SEQ_W-1:0]  lost_now;
        logic [CNT_W-1:0]  lost_total;
        logic [CNT_W-1:0]  delivered_total;
        logic [CNT_W-1:0]  bytes_total;
    } result_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_wr_t;

endpackage

`default_nettype wire

### src/stop_wait_arq_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Stop-and-wait ARQ receiver. Each transfer on the s_ channel is one frame
// header; each transfer on the m_ channel is its verdict. A data frame whose
// sequence number is below max_seq is classified as duplicate (same number
// as the last frame), old (below the expected number and above half of
// max_seq), future (above a nonzero expected number) or in order. Duplicate
// and old frames are dropped; an old frame is acknowledged with the expected
// number minus one. Every other in-range frame is delivered and moves the
// expected number to its own number plus one, wrapping to zero at max_seq;
// a future frame also adds the skipped count to lost_total. With
// reliable_mode set, every in-range data frame gets an acknowledgement with
// addresses and ids swapped; ack fields read zero when no ack is sent.
// Non-data frames and numbers at or above max_seq change no state. Totals
// wrap at 32 bits. Throughput is one frame per clock while m_ready is high:
// the header is held in an input register, classified, and the state updated
// as the verdict loads into an output register that holds it. m_valid rises
// once the header has passed both registers; a held verdict with m_ready low
// stalls the path. Write max_seq (index 0) and reliable_mode (index 1) only
// while no frame is in flight.
module stop_wait_arq_receiver (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // Configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [swarq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [swarq_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // Frame header channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_frame_kind,
    input  wire logic [swarq_pkg::SEQ_W-1:0]         s_seq_num,
    input  wire logic [swarq_pkg::ADDR_W-1:0]        s_source_addr,
    input  wire logic [swarq_pkg::ADDR_W-1:0]        s_dest_addr,
    input  wire logic [swarq_pkg::ID_W-1:0]          s_source_id,
    input  wire logic [swarq_pkg::ID_W-1:0]          s_dest_id,
    input  wire logic [swarq_pkg::LEN_W-1:0]         s_payload_bytes,

    // Verdict channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [1:0]                               m_status,
    output logic                                     m_deliver,
    output logic                                     m_send_ack,
    output logic [swarq_pkg::SEQ_W-1:0]              m_ack_seq,
    output logic [swarq_pkg::ADDR_W-1:0]             m_ack_dest_addr,
    output logic [swarq_pkg::ADDR_W-1:0]             m_ack_source_addr,
    output logic [swarq_pkg::ID_W-1:0]               m_ack_dest_id,
    output logic [swarq_pkg::ID_W-1:0]               m_ack_source_id,
    output logic [swarq_pkg::SEQ_W-1:0]              m_lost_now,
    output logic [swarq_pkg::CNT_W-1:0]              m_lost_total,
    output logic [swarq_pkg::CNT_W-1:0]              m_delivered_total,
    output logic [swarq_pkg::CNT_W-1:0]              m_bytes_total
);

    swarq_pkg::cfg_wr_t cfg;
    swarq_pkg::frame_t  s_frame;
    swarq_pkg::frame_t  frame;
    swarq_pkg::result_t result;
    swarq_pkg::result_t m_result;
    logic               frame_valid;
    logic               take;
    logic               out_ready;

    // Bundle the configuration write
    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    // Gather the header fields into one word for the input register
    assign s_frame.frame_kind    = s_frame_kind;
    assign s_frame.seq_num       = s_seq_num;
    assign s_frame.source_addr   = s_source_addr;
    assign s_frame.dest_addr     = s_dest_addr;
    assign s_frame.source_id     = s_source_id;
    assign s_frame.dest_id       = s_dest_id;
    assign s_frame.payload_bytes = s_payload_bytes;

    // Input register: hold one header; refill in the cycle it is consumed
    swarq_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frame     (s_frame),
        .take        (take),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    // Classifier and sequence state: advance state only when the verdict
    // has room in the output register
    swarq_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .frame_valid (frame_valid),
        .frame       (frame),
        .out_ready   (out_ready),
        .take        (take),
        .result      (result)
    );

    // Output register: hold the verdict until the m_ transfer
    swarq_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take),
        .result_in (result),
        .out_ready (out_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    // Spread the verdict onto its ports
    assign m_status          = m_result.status;
    assign m_deliver         = m_result.deliver;
    assign m_send_ack        = m_result.send_ack;
    assign m_ack_seq         = m_result.ack_seq;
    assign m_ack_dest_addr   = m_result.ack_dest_addr;
    assign m_ack_source_addr = m_result.ack_source_addr;
    assign m_ack_dest_id     = m_result.ack_dest_id;
    assign m_ack_source_id   = m_result.ack_source_id;
    assign m_lost_now        = m_result.lost_now;
    assign m_lost_total      = m_result.lost_total;
    assign m_delivered_total = m_result.delivered_total;
    assign m_bytes_total     = m_result.bytes_total;

endmodule

`default_nettype wire

### src/swarq_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module swarq_in_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire swarq_pkg::frame_t s_frame,
    input  wire logic             take,
    output logic                  frame_valid,
    output swarq_pkg::frame_t     frame
);

    logic              valid_reg;
    logic              valid_next;
    swarq_pkg::frame_t frame_reg;

    // Free the slot when the core consumes the held frame
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            frame_reg <= s_frame;
        end
    end

    assign frame_valid = valid_reg;
    assign frame       = frame_reg;

endmodule

`default_nettype wire

### src/swarq_core.sv
`timescale 1ns / 1ps
`default_nettype none

module swarq_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire swarq_pkg::cfg_wr_t  cfg,
    input  wire logic               frame_valid,
    input  wire swarq_pkg::frame_t   frame,
    input  wire logic               out_ready,
    output logic                    take,
    output swarq_pkg::result_t      result
);

    logic [swarq_pkg::SEQ_W-1:0] max_seq_reg;
    logic                        reliable_reg;

    logic [swarq_pkg::SEQ_W-1:0] last_seq_reg;
    logic [swarq_pkg::SEQ_W-1:0] last_seq_next;
    logic [swarq_pkg::SEQ_W-1:0] expected_reg;
    logic [swarq_pkg::SEQ_W-1:0] expected_next;
    logic [swarq_pkg::CNT_W-1:0] lost_reg;
    logic [swarq_pkg::CNT_W-1:0] lost_next;
    logic [swarq_pkg::CNT_W-1:0] delivered_reg;
    logic [swarq_pkg::CNT_W-1:0] delivered_next;
    logic [swarq_pkg::CNT_W-1:0] bytes_reg;
    logic [swarq_pkg::CNT_W-1:0] bytes_next;

    logic                        in_range;
    logic                        is_dup;
    logic                        is_old;
    logic                        is_future;
    logic                        accept_frame;
    logic [swarq_pkg::SEQ_W-1:0] half_max;
    logic [swarq_pkg::SEQ_W-1:0] ack_no;
    logic [swarq_pkg::SEQ_W-1:0] gap;
    logic [swarq_pkg::SEQ_W:0]   seq_plus;

    assign take = frame_valid && out_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_seq_reg  <= swarq_pkg::MAX_SEQ_RST;
            reliable_reg <= swarq_pkg::RELIABLE_RST;
        end else if (cfg.we) begin
            unique case (cfg.index)
                swarq_pkg::REG_MAX_SEQ:  max_seq_reg  <= cfg.wdata;
                swarq_pkg::REG_RELIABLE: reliable_reg <= cfg.wdata[0];
                default: ;
            endcase
        end
    end

    // Classify the frame against the kept sequence state
    assign half_max  = {1'b0, max_seq_reg[swarq_pkg::SEQ_W-1:1]};
    assign in_range  = (frame.frame_kind == 1'b0) && (frame.seq_num < max_seq_reg);
    assign is_dup    = (frame.seq_num == last_seq_reg);
    assign is_old    = !is_dup && (frame.seq_num < expected_reg) && (frame.seq_num > half_max);
    assign is_future = !is_dup && !is_old && (frame.seq_num > expected_reg)
                       && (expected_reg != '0);
    assign accept_frame = in_range && !is_dup && !is_old;
    assign gap       = is_future ? (frame.seq_num - expected_reg) : '0;
    assign seq_plus  = {1'b0, frame.seq_num} + {{swarq_pkg::SEQ_W{1'b0}}, 1'b1};

    always_comb begin
        if (is_old) begin
            ack_no = (expected_reg == '0) ? '0
                     : expected_reg - {{(swarq_pkg::SEQ_W-1){1'b0}}, 1'b1};
        end else begin
            ack_no = frame.seq_num;
        end
    end

    always_comb begin
        last_seq_next  = last_seq_reg;
        expected_next  = expected_reg;
        lost_next      = lost_reg;
        delivered_next = delivered_reg;
        bytes_next     = bytes_reg;
        if (in_range) begin
            last_seq_next = frame.seq_num;
            lost_next     = lost_reg
                            + {{(swarq_pkg::CNT_W-swarq_pkg::SEQ_W){1'b0}}, gap};
        end
        if (accept_frame) begin
            expected_next  = (seq_plus >= {1'b0, max_seq_reg}) ? '0
                             : seq_plus[swarq_pkg::SEQ_W-1:0];
            delivered_next = delivered_reg + {{(swarq_pkg::CNT_W-1){1'b0}}, 1'b1};
            bytes_next     = bytes_reg
                             + {{(swarq_pkg::CNT_W-swarq_pkg::LEN_W){1'b0}},
                                frame.payload_bytes};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seq_reg  <= '0;
            expected_reg  <= '0;
            lost_reg      <= '0;
            delivered_reg <= '0;
            bytes_reg     <= '0;
        end else if (take) begin
            last_seq_reg  <= last_seq_next;
            expected_reg  <= expected_next;
            lost_reg      <= lost_next;
            delivered_reg <= delivered_next;
            bytes_reg     <= bytes_next;
        end
    end

    always_comb begin
        result = '0;
        priority if (frame.frame_kind != 1'b0) begin
            result.status = swarq_pkg::STAT_NOT_DATA;
        end else if (!in_range) begin
            result.status = swarq_pkg::STAT_RANGE;
        end else begin
            result.status = swarq_pkg::STAT_OK;
        end
        result.deliver  = accept_frame;
        result.send_ack = in_range && reliable_reg;
        if (in_range && reliable_reg) begin
            result.ack_seq         = ack_no;
            result.ack_dest_addr   = frame.source_addr;
            result.ack_source_addr = frame.dest_addr;
            result.ack_dest_id     = frame.source_id;
            result.ack_source_id   = frame.dest_id;
        end
        result.lost_now        = in_range ? gap : '0;
        result.lost_total      = lost_next;
        result.delivered_total = delivered_next;
        result.bytes_total     = bytes_next;
    end

    a_deliver_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        take && result.deliver |-> result.status == swarq_pkg::STAT_OK)
        else $error("delivered frame without ok status");

    a_reject_holds_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        take && result.status != swarq_pkg::STAT_OK
        |=> $stable(expected_reg) && $stable(last_seq_reg))
        else $error("rejected frame changed sequence state");

    a_deliver_count: assert property (@(posedge aclk) disable iff (!aresetn)
        take && result.deliver
        |=> delivered_reg == $past(delivered_reg) + {{(swarq_pkg::CNT_W-1){1'b0}}, 1'b1})
        else $error("delivered count did not advance by one");

    a_ack_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        take && result.send_ack |-> reliable_reg && result.status == swarq_pkg::STAT_OK)
        else $error("acknowledgement for a rejected frame");

endmodule

`default_nettype wire

### src/swarq_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module swarq_out_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire swarq_pkg::result_t  result_in,
    output logic                    out_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output swarq_pkg::result_t      m_result
);

    logic               valid_reg;
    logic               valid_next;
    swarq_pkg::result_t result_reg;

    // Accept a new result when empty or when the held one drains now
    assign out_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

### sim/stop_wait_arq_receiver_tb.sv
`timescale 1ns / 1ps

// Frame headers go in on the s_ channel. Verdicts come back on the m_ channel, one per header.
// A driver and a monitor run as clocked processes. The monitor predicts each verdict when the
// header transfer happens. It then checks every verdict transfer against the oldest prediction.
module stop_wait_arq_receiver_tb;

    localparam int SEQ_W      = swarq_pkg::SEQ_W;
    localparam int ADDR_W     = swarq_pkg::ADDR_W;
    localparam int ID_W       = swarq_pkg::ID_W;
    localparam int LEN_W      = swarq_pkg::LEN_W;
    localparam int CNT_W      = swarq_pkg::CNT_W;
    localparam int CFG_IDX_W  = swarq_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = swarq_pkg::CFG_DATA_W;

    localparam int DRAIN_CYCLES    = 6;     // extra wait after the last verdict before the next phase
    localparam int HOLD_CYCLES     = 400;   // long receiver hold-off to fill the block
    localparam int WATCHDOG_CYCLES = 4000;  // cycles without any transfer before giving up

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    swarq_pkg::frame_t s_frame = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic              m_deliver;
    logic              m_send_ack;
    logic [SEQ_W-1:0]  m_ack_seq;
    logic [ADDR_W-1:0] m_ack_dest_addr;
    logic [ADDR_W-1:0] m_ack_source_addr;
    logic [ID_W-1:0]   m_ack_dest_id;
    logic [ID_W-1:0]   m_ack_source_id;
    logic [SEQ_W-1:0]  m_lost_now;
    logic [CNT_W-1:0]  m_lost_total;
    logic [CNT_W-1:0]  m_delivered_total;
    logic [CNT_W-1:0]  m_bytes_total;

    // Headers waiting to be offered, and verdicts predicted but not yet seen
    swarq_pkg::frame_t  pending_frames[$];
    swarq_pkg::result_t expected_verdicts[$];

    // Receiver-side copy of the block: configuration and sequence state
    logic [SEQ_W-1:0] cfg_modulus  = swarq_pkg::MAX_SEQ_RST;
    logic             cfg_reliable = swarq_pkg::RELIABLE_RST;
    logic [SEQ_W-1:0] rx_expected  = '0;
    logic [SEQ_W-1:0] rx_last      = '0;
    logic [CNT_W-1:0] lost_sum     = '0;
    logic [CNT_W-1:0] delivered_sum = '0;
    logic [CNT_W-1:0] byte_sum     = '0;

    // Traffic shaping knobs, set per phase by the main sequence
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_taken     = 0;
    int hold_left      = 0;

    // Sequence tracking on the sending side, used only to shape traffic
    int tx_next = 0;
    int tx_last = 0;

    logic               frame_taken = 1'b0;
    int                 quiet_cycles = 0;
    int                 error_count  = 0;
    swarq_pkg::frame_t  next_frame;
    swarq_pkg::result_t head_verdict;

    stop_wait_arq_receiver DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_frame_kind      (s_frame.frame_kind),
        .s_seq_num         (s_frame.seq_num),
        .s_source_addr     (s_frame.source_addr),
        .s_dest_addr       (s_frame.dest_addr),
        .s_source_id       (s_frame.source_id),
        .s_dest_id         (s_frame.dest_id),
        .s_payload_bytes   (s_frame.payload_bytes),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_deliver         (m_deliver),
        .m_send_ack        (m_send_ack),
        .m_ack_seq         (m_ack_seq),
        .m_ack_dest_addr   (m_ack_dest_addr),
        .m_ack_source_addr (m_ack_source_addr),
        .m_ack_dest_id     (m_ack_dest_id),
        .m_ack_source_id   (m_ack_source_id),
        .m_lost_now        (m_lost_now),
        .m_lost_total      (m_lost_total),
        .m_delivered_total (m_delivered_total),
        .m_bytes_total     (m_bytes_total)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Classify one header against the kept state, update that state, and return the verdict.
    function automatic swarq_pkg::result_t classify_frame(input swarq_pkg::frame_t f);
        swarq_pkg::result_t v;
        logic               keep;
        logic [SEQ_W-1:0]   ack_no;
        logic [SEQ_W:0]     next_seq;
        v      = '0;
        keep   = 1'b0;
        ack_no = '0;
        if (f.frame_kind) begin
            v.status = swarq_pkg::STAT_NOT_DATA;
        end else if (f.seq_num >= cfg_modulus) begin
            v.status = swarq_pkg::STAT_RANGE;
        end else begin
            v.status = swarq_pkg::STAT_OK;
            keep     = 1'b1;
            ack_no   = f.seq_num;
            if (f.seq_num == rx_last) begin
                // duplicate of the previous frame: drop
                keep = 1'b0;
            end else if (f.seq_num < rx_expected && f.seq_num > (cfg_modulus >> 1)) begin
                // old frame: drop, re-acknowledge the last good number
                keep   = 1'b0;
                ack_no = (rx_expected == '0) ? '0 : rx_expected - SEQ_W'(1);
            end else if (f.seq_num > rx_expected && rx_expected != '0) begin
                // future frame: count the skipped numbers as lost
                v.lost_now = f.seq_num - rx_expected;
                lost_sum   = lost_sum + {{(CNT_W-SEQ_W){1'b0}}, v.lost_now};
            end
            v.send_ack = cfg_reliable;
            if (keep) begin
                next_seq      = {1'b0, ack_no} + (SEQ_W+1)'(1);
                v.deliver     = 1'b1;
                rx_expected   = (next_seq >= {1'b0, cfg_modulus}) ? '0 : next_seq[SEQ_W-1:0];
                delivered_sum = delivered_sum + CNT_W'(1);
                byte_sum      = byte_sum + {{(CNT_W-LEN_W){1'b0}}, f.payload_bytes};
            end
            rx_last = f.seq_num;
        end
        // Swap addresses and ids into the acknowledgement; zeros when none is sent
        if (v.send_ack) begin
            v.ack_seq         = ack_no;
            v.ack_dest_addr   = f.source_addr;
            v.ack_source_addr = f.dest_addr;
            v.ack_dest_id     = f.source_id;
            v.ack_source_id   = f.dest_id;
        end
        v.lost_total      = lost_sum;
        v.delivered_total = delivered_sum;
        v.bytes_total     = byte_sum;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Sender: change at the falling edge. Hold the header until it transfers, then advance.
    always @(negedge aclk) begin
        if (!s_valid || frame_taken) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_frame = pending_frames.pop_front();
                s_frame <= next_frame;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: a requested hold-off drops ready for a fixed stretch; otherwise stall at random.
    always @(negedge aclk) begin
        if (hold_taken != hold_req) begin
            hold_taken <= hold_req;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: sample at the rising edge. Predict on header transfers and check verdict transfers.
    always @(posedge aclk) begin
        frame_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_verdicts.push_back(classify_frame(s_frame));
            end
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("verdict with none expected", 32'(m_status), '0);
                end else begin
                    head_verdict = expected_verdicts.pop_front();
                    check_field("status", 32'(m_status), 32'(head_verdict.status));
                    check_field("deliver", 32'(m_deliver), 32'(head_verdict.deliver));
                    check_field("send_ack", 32'(m_send_ack), 32'(head_verdict.send_ack));
                    check_field("ack_seq", 32'(m_ack_seq), 32'(head_verdict.ack_seq));
                    check_field("ack_dest_addr", 32'(m_ack_dest_addr),
                                32'(head_verdict.ack_dest_addr));
                    check_field("ack_source_addr", 32'(m_ack_source_addr),
                                32'(head_verdict.ack_source_addr));
                    check_field("ack_dest_id", 32'(m_ack_dest_id),
                                32'(head_verdict.ack_dest_id));
                    check_field("ack_source_id", 32'(m_ack_source_id),
                                32'(head_verdict.ack_source_id));
                    check_field("lost_now", 32'(m_lost_now), 32'(head_verdict.lost_now));
                    check_field("lost_total", m_lost_total, head_verdict.lost_total);
                    check_field("delivered_total", m_delivered_total,
                                head_verdict.delivered_total);
                    check_field("bytes_total", m_bytes_total, head_verdict.bytes_total);
                end
            end
        end
        // Watchdog: any transfer on either channel counts as progress
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Write one register at the falling edge and mirror it into the local copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == swarq_pkg::REG_MAX_SEQ) begin
            cfg_modulus = data;
        end else if (idx == swarq_pkg::REG_RELIABLE) begin
            cfg_reliable = data[0];
        end
    endtask

    task automatic queue_frame(input logic kind, input logic [SEQ_W-1:0] seq,
                               input logic [LEN_W-1:0] bytes);
        swarq_pkg::frame_t f;
        f.frame_kind    = kind;
        f.seq_num       = seq;
        f.source_addr   = ADDR_W'($urandom);
        f.dest_addr     = ADDR_W'($urandom);
        f.source_id     = ID_W'($urandom);
        f.dest_id       = ID_W'($urandom);
        f.payload_bytes = bytes;
        pending_frames.push_back(f);
    endtask

    // Mostly in-order and future frames. Mix in duplicates, old numbers, numbers out of
    // range, and other frame types.
    task automatic gen_traffic(input int count);
        int                pick;
        int                modulus;
        swarq_pkg::frame_t f;
        modulus = int'(cfg_modulus);
        for (int i = 0; i < count; i++) begin
            pick            = $urandom_range(99);
            f.frame_kind    = (pick < 5);
            f.source_addr   = ADDR_W'($urandom);
            f.dest_addr     = ADDR_W'($urandom);
            f.source_id     = ID_W'($urandom);
            f.dest_id       = ID_W'($urandom);
            f.payload_bytes = LEN_W'($urandom);
            if (pick < 5) begin
                f.seq_num = SEQ_W'($urandom);
            end else if (pick < 10) begin
                f.seq_num = SEQ_W'($urandom_range(65535, modulus));
            end else if (pick < 18) begin
                f.seq_num = SEQ_W'(tx_last);
            end else if (pick < 26) begin
                f.seq_num = SEQ_W'($urandom_range(modulus - 1, 0));
            end else if (pick < 36) begin
                f.seq_num = SEQ_W'((tx_next + int'($urandom_range(40, 1))) % modulus);
            end else begin
                f.seq_num = SEQ_W'(tx_next % modulus);
            end
            if (!f.frame_kind && int'(f.seq_num) < modulus) begin
                tx_last = int'(f.seq_num);
                if (pick >= 26) begin
                    tx_next = (int'(f.seq_num) + 1) % modulus;
                end
            end
            pending_frames.push_back(f);
        end
    endtask

    // Wait until every header has gone in and every verdict has come out. Then let the pipe settle.
    task automatic wait_drained();
        while (pending_frames.size() != 0 || s_valid || expected_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [SEQ_W-1:0] modulus, input logic reliable,
                             input int idle_pct, input int stall_pct, input int count,
                             input bit with_hold);
        write_reg(swarq_pkg::REG_MAX_SEQ, modulus);
        // Keep the upper data bits random; only bit 0 matters
        write_reg(swarq_pkg::REG_RELIABLE, {(CFG_DATA_W-1)'($urandom), reliable});
        @(posedge aclk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        gen_traffic(count);
        if (with_hold) begin
            hold_req++;
        end
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // Directed checks use the reset configuration: modulus 65535, acknowledgements on
        pending_frames.push_back('{1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
        pending_frames.push_back('0);        // number zero repeats the reset last number
        queue_frame(1'b0, 16'hFFFF, LEN_W'($urandom)); // at the modulus: out of range
        queue_frame(1'b0, 16'd1, 16'hFFFF);  // first delivery, largest payload
        queue_frame(1'b0, 16'd1, LEN_W'($urandom));  // duplicate
        queue_frame(1'b0, 16'd5, LEN_W'($urandom));  // future: three lost
        queue_frame(1'b0, 16'd6, LEN_W'($urandom));  // in order
        queue_frame(1'b0, 16'd65534, 16'd0); // future, expected number wraps to zero
        queue_frame(1'b0, 16'd0, LEN_W'($urandom));  // in order after the wrap
        queue_frame(1'b0, 16'd40000, LEN_W'($urandom));
        queue_frame(1'b0, 16'd35000, LEN_W'($urandom)); // old: upper half and below expected
        queue_frame(1'b0, 16'd100, LEN_W'($urandom));   // below expected but in the lower half
        queue_frame(1'b1, 16'd101, LEN_W'($urandom));   // other frame type leaves state alone
        queue_frame(1'b0, 16'd101, 16'hFFFF);
        queue_frame(1'b0, 16'd101, LEN_W'($urandom));   // duplicate
        wait_drained();

        // Random phases: sweep the modulus across its range and vary the idle patterns.
        // The first phase also holds off the receiver while the sender keeps offering.
        run_phase(16'hFFFF, 1'b0, 0, 0, 250, 1'b1);
        run_phase(16'd2, 1'b1, 71, 0, 250, 1'b0);
        run_phase(16'd7, 1'b0, 0, 71, 250, 1'b0);
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
        run_phase(16'd300, 1'b1, 13, 13, 250, 1'b0);
        run_phase(16'd40000, 1'b1, 0, 0, 250, 1'b0);
        run_phase(SEQ_W'($urandom_range(65535, 2)), 1'($urandom_range(1)), 13, 13, 250, 1'b0);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
src/swarq_pkg.sv
src/swarq_in_reg.sv
src/swarq_core.sv
src/swarq_out_reg.sv
src/stop_wait_arq_receiver.sv
sim/stop_wait_arq_receiver_tb.sv
